/* hdl/mile_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_pkg - shared types and constants of the moving image LED frame block
// Sizes of the strip and image store, register map, config record, controller
// states and the command/status records between controller and datapath.
// ----------------------------------------------------------------------------
package mile_pkg;

	localparam int MAX_LEDS         = 64;
	localparam int MAX_IMAGE_WIDTH  = 64;
	localparam int MAX_IMAGE_HEIGHT = 256;
	localparam int LED_W            = 6;
	localparam int COL_W            = 6;
	localparam int ROW_W            = 8;
	localparam int ADDR_W           = COL_W + ROW_W;
	localparam int STORE_DEPTH      = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
	localparam int RGBA_W           = 32;
	localparam int ITER_W           = 12;
	localparam int POS_W            = 17;
	localparam int PADDR_W          = 5;
	localparam int PDATA_W          = 32;

	localparam logic [POS_W-1:0] ONE_Q16 = 17'd65536;

	// register map, index = paddr[4:2]
	localparam logic [2:0] REG_LED_COUNT        = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd1;
	localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd2;
	localparam logic [2:0] REG_OBJ_SPAN         = 3'd3;
	localparam logic [2:0] REG_OBJ_CENTRE       = 3'd4;
	localparam logic [2:0] REG_FIRST_FRAME      = 3'd5;
	localparam logic [2:0] REG_ANIMATION_LENGTH = 3'd6;
	localparam logic [2:0] REG_MIRROR_FLAGS     = 3'd7;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_RENDER = 1'b1;

	typedef struct packed {
		logic [6:0]         led_count;
		logic [6:0]         image_width;
		logic [8:0]         image_height;
		logic [6:0]         obj_span;
		logic signed [7:0]  obj_centre;
		logic signed [10:0] first_frame;
		logic [11:0]        animation_length;
		logic [1:0]         mirror_flags;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EDGE,
		ST_CLIP,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic mul;
		logic edges;
		logic clip;
		logic issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic can_issue;
		logic issue_last;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hdl/mile_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_if - item channels of the moving image LED frame block
// Job channel (pixel loads and render requests) and LED result channel.
// ----------------------------------------------------------------------------
interface mile_job_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [mile_pkg::COL_W-1:0]      pixel_column;
	logic [mile_pkg::ROW_W-1:0]      pixel_row;
	logic [mile_pkg::RGBA_W-1:0]     pixel_rgba;
	logic [mile_pkg::ITER_W-1:0]     frame_iteration;
	logic [mile_pkg::POS_W-1:0]      position;

	modport source (
		output valid, kind, pixel_column, pixel_row, pixel_rgba, frame_iteration, position,
		input  ready
	);
	modport sink (
		input  valid, kind, pixel_column, pixel_row, pixel_rgba, frame_iteration, position,
		output ready
	);
endinterface

interface mile_led_if;
	logic                            valid;
	logic                            ready;
	logic [mile_pkg::LED_W-1:0]      led_number;
	logic [mile_pkg::RGBA_W-1:0]     led_rgba;
	logic                            last_led;

	modport source (
		output valid, led_number, led_rgba, last_led,
		input  ready
	);
	modport sink (
		input  valid, led_number, led_rgba, last_led,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/mile_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_cfg - configuration registers
// APB-style write/read of the eight setup registers, 4-byte stride.
// ----------------------------------------------------------------------------
module mile_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mile_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mile_pkg::PDATA_W-1:0]   pwdata,
	output logic      [mile_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	output mile_pkg::cfg_t                      cfg
);

	mile_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count        <= 7'd46;
			cfg_q.image_width      <= 7'd64;
			cfg_q.image_height     <= 9'd256;
			cfg_q.obj_span         <= 7'd0;
			cfg_q.obj_centre       <= 8'sd0;
			cfg_q.first_frame      <= 11'sd0;
			cfg_q.animation_length <= 12'd256;
			cfg_q.mirror_flags     <= 2'd0;
		end else if (wr_en) begin
			case (idx)
				mile_pkg::REG_LED_COUNT:        cfg_q.led_count        <= pwdata[6:0];
				mile_pkg::REG_IMAGE_WIDTH:      cfg_q.image_width      <= pwdata[6:0];
				mile_pkg::REG_IMAGE_HEIGHT:     cfg_q.image_height     <= pwdata[8:0];
				mile_pkg::REG_OBJ_SPAN:         cfg_q.obj_span         <= pwdata[6:0];
				mile_pkg::REG_OBJ_CENTRE:       cfg_q.obj_centre       <= $signed(pwdata[7:0]);
				mile_pkg::REG_FIRST_FRAME:      cfg_q.first_frame      <= $signed(pwdata[10:0]);
				mile_pkg::REG_ANIMATION_LENGTH: cfg_q.animation_length <= pwdata[11:0];
				mile_pkg::REG_MIRROR_FLAGS:     cfg_q.mirror_flags     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mile_pkg::REG_LED_COUNT:        prdata = {25'd0, cfg_q.led_count};
			mile_pkg::REG_IMAGE_WIDTH:      prdata = {25'd0, cfg_q.image_width};
			mile_pkg::REG_IMAGE_HEIGHT:     prdata = {23'd0, cfg_q.image_height};
			mile_pkg::REG_OBJ_SPAN:         prdata = {25'd0, cfg_q.obj_span};
			mile_pkg::REG_OBJ_CENTRE:       prdata = {24'd0, cfg_q.obj_centre};
			mile_pkg::REG_FIRST_FRAME:      prdata = {21'd0, cfg_q.first_frame};
			mile_pkg::REG_ANIMATION_LENGTH: prdata = {20'd0, cfg_q.animation_length};
			mile_pkg::REG_MIRROR_FLAGS:     prdata = {30'd0, cfg_q.mirror_flags};
			default:                        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/mile_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_ctrl - sequencing of loads and frame renders
// Idle takes loads and stays idle; a render runs multiply, edge, clip, then
// one LED issue per cycle while the datapath has room.
// ----------------------------------------------------------------------------
module mile_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	input  wire logic                job_kind,
	output logic                     job_ready,
	input  wire mile_pkg::dp_stat_t  stat,
	output mile_pkg::ctrl_cmd_t      cmd
);

	mile_pkg::state_t state_q;
	mile_pkg::state_t state_d;
	logic             acc;

	assign acc = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mile_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mile_pkg::ST_IDLE: begin
				if (acc && (job_kind == mile_pkg::KIND_RENDER) && !stat.n_zero) begin
					state_d = mile_pkg::ST_MUL;
				end
			end
			mile_pkg::ST_MUL:  state_d = mile_pkg::ST_EDGE;
			mile_pkg::ST_EDGE: state_d = mile_pkg::ST_CLIP;
			mile_pkg::ST_CLIP: state_d = mile_pkg::ST_RUN;
			mile_pkg::ST_RUN: begin
				if (stat.can_issue && stat.issue_last) begin
					state_d = mile_pkg::ST_IDLE;
				end
			end
			default: state_d = mile_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready   = 1'b0;
		cmd         = '0;
		case (state_q)
			mile_pkg::ST_IDLE: begin
				job_ready   = 1'b1;
				cmd.load    = acc && (job_kind == mile_pkg::KIND_LOAD);
				cmd.capture = acc && (job_kind == mile_pkg::KIND_RENDER);
			end
			mile_pkg::ST_MUL:  cmd.mul   = 1'b1;
			mile_pkg::ST_EDGE: cmd.edges = 1'b1;
			mile_pkg::ST_CLIP: cmd.clip  = 1'b1;
			mile_pkg::ST_RUN:  cmd.issue = stat.can_issue;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/mile_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_dp - frame geometry, image store and LED output pipeline
// Position multiply, window edges and clipping, then per LED a store read
// (stage 1) and an output register that decouples the result side.
// ----------------------------------------------------------------------------
module mile_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mile_pkg::cfg_t                  cfg,
	input  wire mile_pkg::ctrl_cmd_t             cmd,
	output mile_pkg::dp_stat_t                   stat,
	input  wire logic [mile_pkg::COL_W-1:0]      pixel_column,
	input  wire logic [mile_pkg::ROW_W-1:0]      pixel_row,
	input  wire logic [mile_pkg::RGBA_W-1:0]     pixel_rgba,
	input  wire logic [mile_pkg::ITER_W-1:0]     frame_iteration,
	input  wire logic [mile_pkg::POS_W-1:0]      position,
	output logic                                 led_valid,
	input  wire logic                            led_ready,
	output logic      [mile_pkg::LED_W-1:0]      led_number,
	output logic      [mile_pkg::RGBA_W-1:0]     led_rgba,
	output logic                                 last_led
);

	function automatic logic [6:0] clamp_n(input logic signed [10:0] x, input logic [6:0] hi);
		logic [6:0] r;
		if (x < 11'sd0)
			r = 7'd0;
		else if (x > $signed({4'd0, hi}))
			r = hi;
		else
			r = x[6:0];
		return r;
	endfunction

	function automatic logic signed [13:0] clamp_a(input logic signed [13:0] x,
		input logic signed [13:0] hi);
		logic signed [13:0] r;
		if (x < 14'sd0)
			r = 14'sd0;
		else if (x > hi)
			r = hi;
		else
			r = x;
		return r;
	endfunction

	logic [mile_pkg::RGBA_W-1:0] mem [mile_pkg::STORE_DEPTH];

	// effective sizes
	logic [6:0]               n;
	logic [6:0]               w;
	logic [8:0]               h;
	logic [16:0]              p_clamp;
	logic [16:0]              p_eff;
	logic signed [7:0]        d;

	// render setup registers
	logic [11:0]              iter_q;
	logic [16:0]              p_q;
	logic signed [7:0]        d_q;
	logic signed [25:0]       prod_q;
	logic signed [9:0]        left_q;
	logic signed [10:0]       right_q;
	logic [6:0]               lr_q;
	logic [6:0]               rr_q;
	logic                     rowok_q;
	logic [7:0]               row_q;
	logic [5:0]               cnt_q;

	// edge step
	logic signed [25:0]       prod_neg;
	logic [9:0]               mag_hi;
	logic signed [9:0]        t;
	logic signed [9:0]        offs;
	logic signed [9:0]        left;

	// clip step
	logic signed [13:0]       top;
	logic signed [13:0]       bottom;
	logic signed [13:0]       alen;
	logic signed [13:0]       tr;
	logic signed [13:0]       br;
	logic signed [13:0]       iter_s;

	// LED issue
	logic [9:0]                    diff;
	logic [5:0]                    col;
	logic [mile_pkg::ADDR_W-1:0]   rd_addr;
	logic                          inwin;
	logic                          adv;

	logic                     v_s1;
	logic                     inwin_s1;
	logic [5:0]               num_s1;
	logic                     last_s1;
	logic [31:0]              rd_s1;

	logic                     led_valid_q;
	logic [5:0]               led_number_q;
	logic [31:0]              led_rgba_q;
	logic                     last_led_q;

	assign n = (cfg.led_count > 7'(mile_pkg::MAX_LEDS)) ? 7'(mile_pkg::MAX_LEDS) : cfg.led_count;
	assign w = (cfg.image_width > 7'(mile_pkg::MAX_IMAGE_WIDTH)) ?
		7'(mile_pkg::MAX_IMAGE_WIDTH) : cfg.image_width;
	assign h = (cfg.image_height > 9'(mile_pkg::MAX_IMAGE_HEIGHT)) ?
		9'(mile_pkg::MAX_IMAGE_HEIGHT) : cfg.image_height;

	assign p_clamp = (position > mile_pkg::ONE_Q16) ? mile_pkg::ONE_Q16 : position;
	assign p_eff   = cfg.mirror_flags[1] ? 17'(mile_pkg::ONE_Q16 - p_clamp) : p_clamp;
	assign d       = $signed({1'b0, n}) - $signed({1'b0, cfg.obj_span});

	// truncation toward zero of prod / 65536
	assign prod_neg = -prod_q;
	assign mag_hi   = prod_q[25] ? prod_neg[25:16] : prod_q[25:16];
	assign t        = prod_q[25] ? -$signed(mag_hi) : $signed(mag_hi);
	assign offs     = cfg.mirror_flags[0] ?
		($signed({3'd0, w}) - {{2{cfg.obj_centre[7]}}, cfg.obj_centre}
			- $signed({3'd0, cfg.obj_span})) :
		{{2{cfg.obj_centre[7]}}, cfg.obj_centre};
	assign left     = t - offs;

	assign top    = {{3{cfg.first_frame[10]}}, cfg.first_frame};
	assign bottom = top + $signed({5'd0, h});
	assign alen   = $signed({2'd0, cfg.animation_length});
	assign tr     = clamp_a(top, alen);
	assign br     = clamp_a(bottom, alen);
	assign iter_s = $signed({2'd0, iter_q});

	assign diff    = {4'd0, cnt_q} - left_q;
	assign col     = cfg.mirror_flags[0] ? (w[5:0] - 6'd1 - diff[5:0]) : diff[5:0];
	assign rd_addr = {row_q, col};
	assign inwin   = ({1'b0, cnt_q} >= lr_q) && ({1'b0, cnt_q} < rr_q) && rowok_q;

	assign adv             = !led_valid_q || led_ready;
	assign stat.n_zero     = (n == 7'd0);
	assign stat.can_issue  = !v_s1 || adv;
	assign stat.issue_last = ({1'b0, cnt_q} == 7'(n - 7'd1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			iter_q <= frame_iteration;
			p_q    <= p_eff;
			d_q    <= d;
		end
		if (cmd.mul) begin
			prod_q <= $signed({1'b0, p_q}) * d_q;
		end
		if (cmd.edges) begin
			left_q  <= left;
			right_q <= {left[9], left} + $signed({4'd0, w});
		end
		if (cmd.clip) begin
			lr_q    <= clamp_n({left_q[9], left_q}, n);
			rr_q    <= clamp_n(right_q, n);
			rowok_q <= (iter_s >= tr) && (iter_s < br);
			row_q   <= 8'(iter_q - 12'($unsigned(top)));
		end
	end

	// image store: one write port for loads, one registered read for LEDs
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[{pixel_row, pixel_column}] <= pixel_rgba;
		end
		if (cmd.issue) begin
			rd_s1    <= mem[rd_addr];
			inwin_s1 <= inwin;
			num_s1   <= cnt_q;
			last_s1  <= stat.issue_last;
		end
		if (adv && v_s1) begin
			led_number_q <= num_s1;
			led_rgba_q   <= inwin_s1 ? rd_s1 : '0;
			last_led_q   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			led_valid_q <= 1'b0;
		end else begin
			if (cmd.clip)
				cnt_q <= '0;
			else if (cmd.issue)
				cnt_q <= cnt_q + 6'd1;
			if (cmd.issue)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				led_valid_q <= v_s1;
		end
	end

	assign led_valid  = led_valid_q;
	assign led_number = led_number_q;
	assign led_rgba   = led_rgba_q;
	assign last_led   = last_led_q;

endmodule
`default_nettype wire

/* hdl/moving_image_led_frame.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// moving_image_led_frame - LED strip frame generator from a stored image
// Places a window of a stored RGBA image on an LED strip and emits one value
// per LED for each render item.
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one pixel into the 64 x 256 image store; it
// gives no result. A render item (kind 1) runs setup (accept, position
// multiply, window edges, clipping) and then issues one LED per cycle while
// the result side has room; the single read port of the image store sets
// the one-LED-per-cycle pace. Results leave through an output register, so
// a stalled sink only holds issue once both the read stage and that
// register are full. The next item is taken once the last LED of a frame
// has been issued. The image store has no reset and no clearing pass:
// pixels must be loaded before a frame shows them. The user must write
// registers over the APB port only while no frame is in flight; the block
// does not enforce this. A led_count of zero makes a render item give no items.
// ----------------------------------------------------------------------------
module moving_image_led_frame (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mile_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mile_pkg::PDATA_W-1:0]   pwdata,
	output logic      [mile_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	mile_job_if.sink                            job,
	mile_led_if.source                          led
);

	mile_pkg::cfg_t      cfg;
	mile_pkg::ctrl_cmd_t cmd;
	mile_pkg::dp_stat_t  stat;
	logic                job_ready;
	logic                led_valid;
	logic [5:0]          led_number;
	logic [31:0]         led_rgba;
	logic                last_led;

	// setup registers
	mile_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: owns the job handshake, drives datapath steps
	mile_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_kind  (job.kind),
		.job_ready (job_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// geometry, image store and output pipeline
	mile_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.pixel_column    (job.pixel_column),
		.pixel_row       (job.pixel_row),
		.pixel_rgba      (job.pixel_rgba),
		.frame_iteration (job.frame_iteration),
		.position        (job.position),
		.led_valid       (led_valid),
		.led_ready       (led.ready),
		.led_number      (led_number),
		.led_rgba        (led_rgba),
		.last_led        (last_led)
	);

	assign job.ready      = job_ready;
	assign led.valid      = led_valid;
	assign led.led_number = led_number;
	assign led.led_rgba   = led_rgba;
	assign led.last_led   = last_led;

endmodule
`default_nettype wire

/* hdl/mile_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mile_chk - port-level checks of the moving image LED frame block
// Watches the job and LED channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mile_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	input  wire logic        job_ready,
	input  wire logic        job_kind,
	input  wire logic        led_valid,
	input  wire logic        led_ready,
	input  wire logic [5:0]  led_number,
	input  wire logic [31:0] led_rgba,
	input  wire logic        last_led
);

	// stalled result holds its payload
	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led_ready |=> led_valid && $stable(led_number) && $stable(led_rgba)
			&& $stable(last_led))
		else $error("LED item changed while stalled");

	// the highest LED index can only ever close a frame
	a_top_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && (led_number == 6'(mile_pkg::MAX_LEDS - 1)) |-> last_led)
		else $error("LED at top index not flagged last");

	// a pixel load never leaves the block busy
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready && (job_kind == mile_pkg::KIND_LOAD) |=> job_ready)
		else $error("job channel stalled after a pixel load");

	// nothing is offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !led_valid)
		else $error("LED item shown during reset");

endmodule

bind moving_image_led_frame mile_chk u_mile_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.job_valid  (job.valid),
	.job_ready  (job.ready),
	.job_kind   (job.kind),
	.led_valid  (led.valid),
	.led_ready  (led.ready),
	.led_number (led.led_number),
	.led_rgba   (led.led_rgba),
	.last_led   (led.last_led)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - regression bench for the moving image LED frame block
// Drives pixel loads and render requests into the job channel and register
// settings over APB, predicts every LED value of every frame from a private
// copy of the image store and registers, and checks the LED channel item by
// item under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int SETTLE_CYCLES  = 80;    // frame of 64 LEDs plus setup and output stage
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no accepted item or register access
	localparam int PHASES         = 11;
	localparam int ITEM_TARGET    = 460;   // job items over the whole run

	typedef struct packed {
		logic                        kind;
		logic [mile_pkg::COL_W-1:0]  col;
		logic [mile_pkg::ROW_W-1:0]  row;
		logic [mile_pkg::RGBA_W-1:0] rgba;
		logic [mile_pkg::ITER_W-1:0] iter;
		logic [mile_pkg::POS_W-1:0]  pos;
	} job_item_t;

	typedef struct packed {
		logic [mile_pkg::LED_W-1:0]  number;
		logic [mile_pkg::RGBA_W-1:0] rgba;
		logic                        last;
	} led_item_t;

	// Scoreboard: own copy of the registers and the image store, and the queue
	// of LED values still owed by the block.
	class led_frame_board;
		mile_pkg::cfg_t regs;
		bit [31:0]      pixels [mile_pkg::STORE_DEPTH];
		bit             loaded [mile_pkg::STORE_DEPTH];
		led_item_t      owed_leds [$];
		int             errors;
		int             loads_seen;
		int             frames_seen;
		int             leds_checked;

		function new();
			regs.led_count        = 7'd46;
			regs.image_width      = 7'd64;
			regs.image_height     = 9'd256;
			regs.obj_span         = 7'd0;
			regs.obj_centre       = 8'sd0;
			regs.first_frame      = 11'sd0;
			regs.animation_length = 12'd256;
			regs.mirror_flags     = 2'd0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				mile_pkg::REG_LED_COUNT:        regs.led_count        = v[6:0];
				mile_pkg::REG_IMAGE_WIDTH:      regs.image_width      = v[6:0];
				mile_pkg::REG_IMAGE_HEIGHT:     regs.image_height     = v[8:0];
				mile_pkg::REG_OBJ_SPAN:         regs.obj_span         = v[6:0];
				mile_pkg::REG_OBJ_CENTRE:       regs.obj_centre       = v[7:0];
				mile_pkg::REG_FIRST_FRAME:      regs.first_frame      = v[10:0];
				mile_pkg::REG_ANIMATION_LENGTH: regs.animation_length = v[11:0];
				mile_pkg::REG_MIRROR_FLAGS:     regs.mirror_flags     = v[1:0];
				default: ;
			endcase
		endfunction

		function int leds();
			return (regs.led_count < mile_pkg::MAX_LEDS) ? int'(regs.led_count)
				: mile_pkg::MAX_LEDS;
		endfunction

		function int fit(int x, int lo, int hi);
			if (x < lo)
				return lo;
			if (x > hi)
				return hi;
			return x;
		endfunction

		// Store address shown on LED i for this frame, or -1 where it stays dark.
		function int source_addr(int iter, int pos, int i);
			int n, w, h, ow, co, so, alen, p, prod, t, left, col, row;
			n    = leds();
			w    = (regs.image_width < mile_pkg::MAX_IMAGE_WIDTH) ? int'(regs.image_width)
				: mile_pkg::MAX_IMAGE_WIDTH;
			h    = (regs.image_height < mile_pkg::MAX_IMAGE_HEIGHT) ? int'(regs.image_height)
				: mile_pkg::MAX_IMAGE_HEIGHT;
			ow   = int'(regs.obj_span);
			co   = $signed(regs.obj_centre);
			so   = $signed(regs.first_frame);
			alen = int'(regs.animation_length);
			p    = (pos > int'(mile_pkg::ONE_Q16)) ? int'(mile_pkg::ONE_Q16) : pos;
			if (regs.mirror_flags[1])
				p = int'(mile_pkg::ONE_Q16) - p;
			prod = p * (n - ow);
			t    = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
			left = regs.mirror_flags[0] ? t - (w - co - ow) : t - co;
			if (i < fit(left, 0, n) || i >= fit(left + w, 0, n))
				return -1;
			if (iter < fit(so, 0, alen) || iter >= fit(so + h, 0, alen))
				return -1;
			col = regs.mirror_flags[0] ? w - (i - left) - 1 : i - left;
			row = iter - so;
			if (col < 0 || col >= mile_pkg::MAX_IMAGE_WIDTH || row < 0
				|| row >= mile_pkg::MAX_IMAGE_HEIGHT)
				return -1;
			return row * mile_pkg::MAX_IMAGE_WIDTH + col;
		endfunction

		function void note_job(job_item_t j);
			int n, a;
			led_item_t e;
			if (j.kind == mile_pkg::KIND_LOAD) begin
				pixels[{j.row, j.col}] = j.rgba;
				loaded[{j.row, j.col}] = 1'b1;
				loads_seen++;
			end else begin
				frames_seen++;
				n = leds();
				for (int i = 0; i < n; i++) begin
					a         = source_addr(j.iter, j.pos, i);
					e.number  = i[mile_pkg::LED_W-1:0];
					e.rgba    = (a < 0) ? '0 : pixels[a];
					e.last    = (i == n - 1);
					owed_leds = {owed_leds, e};
				end
			end
		endfunction

		function void check_led(led_item_t got);
			led_item_t want;
			if (owed_leds.size() == 0) begin
				$error("unexpected LED item: led_number %0d led_rgba %h last_led %b",
					got.number, got.rgba, got.last);
				errors++;
				return;
			end
			want = owed_leds.pop_front();
			leds_checked++;
			if (got.number !== want.number) begin
				$error("led_number: expected %0d, actual %0d", want.number, got.number);
				errors++;
			end
			if (got.rgba !== want.rgba) begin
				$error("led_rgba: expected %h, actual %h", want.rgba, got.rgba);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_led: expected %b, actual %b", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return owed_leds.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [mile_pkg::PADDR_W-1:0] paddr;
	logic [mile_pkg::PDATA_W-1:0] pwdata;
	logic [mile_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	mile_job_if job_ch ();
	mile_led_if led_ch ();

	moving_image_led_frame u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.job     (job_ch),
		.led     (led_ch)
	);

	led_frame_board board = new();

	int send_idle_pct;
	int recv_stall_pct;
	int settings_applied;
	int quiet_cycles;
	int jobs_sent;
	int phase_base;
	int phase_end;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// LED sink: check what was taken at this edge, then choose the next ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (led_ch.valid && led_ch.ready)
				board.check_led('{led_ch.led_number, led_ch.led_rgba, led_ch.last_led});
			led_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any job, LED or register access counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((job_ch.valid && job_ch.ready) || (led_ch.valid && led_ch.ready)
				|| (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d LED items owed",
					WATCHDOG_LIMIT, board.pending());
				$display("moving_image_led_frame regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [31:0] reg_mask(logic [2:0] idx);
		case (idx)
			mile_pkg::REG_LED_COUNT, mile_pkg::REG_IMAGE_WIDTH,
			mile_pkg::REG_OBJ_SPAN:         return 32'h7F;
			mile_pkg::REG_IMAGE_HEIGHT:     return 32'h1FF;
			mile_pkg::REG_OBJ_CENTRE:       return 32'hFF;
			mile_pkg::REG_FIRST_FRAME:      return 32'h7FF;
			mile_pkg::REG_ANIMATION_LENGTH: return 32'hFFF;
			default:                        return 32'h3;
		endcase
	endfunction

	// APB write with random junk above the field, then read back the field.
	// Ends with psel dropped and the bus idle.
	task automatic write_reg(logic [2:0] idx, int value);
		logic [31:0] mask;
		logic [31:0] data;
		mask = reg_mask(idx);
		data = (value & mask) | ($urandom & ~mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, data);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (data & mask)) begin
			$error("register %0d readback: expected %h, actual %h", idx, data & mask,
				prdata & mask);
			board.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(int lc, int iw, int ih, int ow, int co, int so, int al,
		int mf);
		write_reg(mile_pkg::REG_LED_COUNT, lc);
		write_reg(mile_pkg::REG_IMAGE_WIDTH, iw);
		write_reg(mile_pkg::REG_IMAGE_HEIGHT, ih);
		write_reg(mile_pkg::REG_OBJ_SPAN, ow);
		write_reg(mile_pkg::REG_OBJ_CENTRE, co);
		write_reg(mile_pkg::REG_FIRST_FRAME, so);
		write_reg(mile_pkg::REG_ANIMATION_LENGTH, al);
		write_reg(mile_pkg::REG_MIRROR_FLAGS, mf);
		settings_applied++;
	endtask

	// Present one job item, with random sender gaps ahead of it. valid is left
	// high on return so that back-to-back items never drop it.
	task automatic send_job(job_item_t j);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			job_ch.valid <= 1'b0;
			@(posedge clk);
		end
		job_ch.valid           <= 1'b1;
		job_ch.kind            <= j.kind;
		job_ch.pixel_column    <= j.col;
		job_ch.pixel_row       <= j.row;
		job_ch.pixel_rgba      <= j.rgba;
		job_ch.frame_iteration <= j.iter;
		job_ch.position        <= j.pos;
		do @(posedge clk); while (!job_ch.ready);
		board.note_job(j);
		jobs_sent++;
	endtask

	// Render fields are random junk on a load item and vice versa.
	function automatic job_item_t make_load(int col, int row, logic [31:0] rgba);
		job_item_t j;
		j.kind = mile_pkg::KIND_LOAD;
		j.col  = col[mile_pkg::COL_W-1:0];
		j.row  = row[mile_pkg::ROW_W-1:0];
		j.rgba = rgba;
		j.iter = $urandom;
		j.pos  = $urandom;
		return j;
	endfunction

	// A render is preceded by loads of any pixel it shows that was never
	// written, so no frame ever reads an undefined store entry.
	task automatic run_render(int iter, int pos);
		job_item_t j;
		int a;
		for (int i = 0; i < board.leds(); i++) begin
			a = board.source_addr(iter, pos, i);
			if (a >= 0 && !board.loaded[a])
				send_job(make_load(a % mile_pkg::MAX_IMAGE_WIDTH,
					a / mile_pkg::MAX_IMAGE_WIDTH, $urandom));
		end
		j.kind = mile_pkg::KIND_RENDER;
		j.col  = $urandom;
		j.row  = $urandom;
		j.rgba = $urandom;
		j.iter = iter[mile_pkg::ITER_W-1:0];
		j.pos  = pos[mile_pkg::POS_W-1:0];
		send_job(j);
	endtask

	// Mostly aim the iteration at a few image rows (edges of the image) so
	// frames are lit and the loads stay few; now and then a random iteration.
	function automatic int pick_iter();
		int row_pool [4] = '{0, 1, 254, 255};
		int it;
		if ($urandom_range(99) < 30)
			return $urandom_range(4095);
		it = row_pool[$urandom_range(3)] + $signed(board.regs.first_frame);
		return (it < 0 || it > 4095) ? $urandom_range(4095) : it;
	endfunction

	function automatic int pick_pos();
		case ($urandom_range(9))
			0:       return 0;
			1:       return mile_pkg::ONE_Q16;
			2:       return $urandom_range(131071, 65537);
			default: return $urandom_range(65535);
		endcase
	endfunction

	task automatic settle();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b1;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		job_ch.valid = 1'b0;
		job_ch.kind  = mile_pkg::KIND_LOAD;
		job_ch.pixel_column    = '0;
		job_ch.pixel_row       = '0;
		job_ch.pixel_rgba      = '0;
		job_ch.frame_iteration = '0;
		job_ch.position        = '0;
		led_ch.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		settings_applied = 0;
		quiet_cycles     = 0;
		jobs_sent        = 0;
		phase_base       = 0;
		phase_end        = 0;
		// clean falling edge so the asynchronous reset takes hold at once
		#1 arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values: corner pixels and bit patterns,
		// then frames at the position extremes, above one, and rows past the image.
		send_job(make_load(63, 255, 32'hFFFF_FFFF));
		send_job(make_load(0, 0, 32'h0000_0000));
		send_job(make_load(42, 85, 32'hA5A5_A5A5));
		send_job(make_load(21, 170, 32'h5A5A_5A5A));
		run_render(0, 0);
		run_render(255, 0);
		run_render(256, 0);
		run_render(4095, 131071);
		run_render(0, mile_pkg::ONE_Q16);
		run_render(0, 65535);
		run_render(85, 32768);
		run_render(170, 65537);
		run_render(1, 16384);

		// the rest of the item budget is shared out over the random phases
		phase_base = jobs_sent;
		for (int ph = 1; ph < PHASES; ph++) begin
			job_ch.valid <= 1'b0;
			settle();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			case (ph)
				// widest legal strip and image, longest animation
				1: apply_setup(64, 64, 256, 0, 0, 0, 4095, 0);
				// single LED, single pixel, object wider than the strip, both mirrors
				2: apply_setup(1, 1, 1, 64, -128, -1024, 1, 3);
				// oversize count, width and height, last frame start, image mirror
				3: apply_setup(127, 127, 511, 127, 127, 1023, 4095, 1);
				// no LEDs: renders give nothing
				4: apply_setup(0, 32, 64, 8, 3, 0, 256, 2);
				// zero width, height and animation length: all dark frames
				5: apply_setup(40, 0, 0, 10, -5, 0, 0, 2);
				default: apply_setup(
					($urandom_range(99) < 70) ? $urandom_range(64, 1) : $urandom_range(127),
					($urandom_range(99) < 70) ? $urandom_range(64, 1) : $urandom_range(127),
					($urandom_range(99) < 60) ? $urandom_range(256, 1) : $urandom_range(511),
					($urandom_range(99) < 60) ? $urandom_range(64) : $urandom_range(127),
					($urandom_range(99) < 60) ? $urandom_range(32) - 16
						: $urandom_range(255) - 128,
					($urandom_range(99) < 60) ? $urandom_range(64) - 32
						: $urandom_range(2047) - 1024,
					($urandom_range(99) < 60) ? $urandom_range(4095, 256) : $urandom_range(4095),
					$urandom_range(3));
			endcase
			phase_end = phase_base + ((ITEM_TARGET - phase_base) * ph) / (PHASES - 1);
			do begin
				if ($urandom_range(99) < 25)
					send_job(make_load($urandom_range(63), $urandom_range(255), $urandom));
				else
					run_render(pick_iter(), pick_pos());
			end while (jobs_sent < phase_end);
		end

		job_ch.valid <= 1'b0;
		settle();
		if (board.pending() != 0) begin
			$error("%0d LED items never arrived", board.pending());
			board.errors++;
		end
		$display("covered %0d pixel loads and %0d frames, %0d LED items checked,",
			board.loads_seen, board.frames_seen, board.leds_checked);
		$display("over %0d register settings and four idle/stall patterns, %0d mismatches",
			settings_applied, board.errors);
		if (board.errors == 0)
			$display("moving_image_led_frame regression: pass");
		else
			$display("moving_image_led_frame regression: fail");
		$finish;
	end

endmodule
